// ----- rtl/monitor_condition_qualifier_assert.svh -----
// Assertion macros for the monitor condition qualifier.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef MONITOR_CONDITION_QUALIFIER_ASSERT_SVH
`define MONITOR_CONDITION_QUALIFIER_ASSERT_SVH
`ifndef ASSERT_OFF
`define MCQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MCQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MCQ_ASSERT_IMP(lbl, ante, cons, msg)
`define MCQ_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/mcq_pkg.sv -----
// Shared types and constants for the monitor condition qualifier.
// Used by mcq_update and monitor_condition_qualifier; no dependencies.
`timescale 1ns / 1ps

package mcq_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int LIMIT_BITS     = 16;
  localparam int IDX_FIELD_BITS = 4;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_ARM    = 1'b1;

  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_MET      = 2'd1;
  localparam logic [1:0] EV_GAVE_UP  = 2'd2;

  typedef struct packed {
    logic                      req_type;
    logic [IDX_FIELD_BITS-1:0] entry_index;
    logic                      is_sim;
    logic                      condition_met;
    logic [LIMIT_BITS-1:0]     skip_limit;
    logic [LIMIT_BITS-1:0]     stable_limit;
    logic [LIMIT_BITS-1:0]     give_up_limit;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                event_res;
    logic [IDX_FIELD_BITS-1:0] event_index;
  } out_item_t;

  // Control produced by the entry update for the table and the result stage.
  typedef struct packed {
    logic       wr_en;
    logic       set_armed;
    logic       clr_armed;
    logic [1:0] event_res;
  } upd_ctl_t;

endpackage

// ----- rtl/mcq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Read-first on a same-address write; no dependencies.
`timescale 1ns / 1ps

module mcq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/mcq_update.sv -----
// Next-state logic for one watch entry: arming, packet counting, run and
// failure counting, and event decision. Depends on mcq_pkg.
`timescale 1ns / 1ps

module mcq_update #(
  parameter int COUNT_BITS = mcq_pkg::COUNT_BITS_DEF,
  localparam int WORD_BITS = 3 * mcq_pkg::LIMIT_BITS + 3 * COUNT_BITS
) (
  input  mcq_pkg::in_item_t     item,
  input  logic                  in_range,
  input  logic                  armed,
  input  logic [WORD_BITS-1:0]  cur_word,
  output logic [WORD_BITS-1:0]  nxt_word,
  output mcq_pkg::upd_ctl_t     ctl
);

  localparam int LB = mcq_pkg::LIMIT_BITS;
  localparam int CMP_BITS = (COUNT_BITS > LB) ? COUNT_BITS : LB;

  logic [LB-1:0]         skip_lim, stable_lim, give_up_lim;
  logic [COUNT_BITS-1:0] pkt_cnt, stab_cnt, fail_cnt;
  logic [COUNT_BITS-1:0] pkt_inc, stab_inc, fail_inc;
  logic [COUNT_BITS-1:0] stab_nxt, fail_nxt;
  logic                  judged, good, fire_met, fire_gu, is_arm;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + COUNT_BITS'(1);
  endfunction

  assign {skip_lim, stable_lim, give_up_lim, pkt_cnt, stab_cnt, fail_cnt} = cur_word;

  assign is_arm   = (item.req_type == mcq_pkg::REQ_ARM);
  assign pkt_inc  = sat_inc(pkt_cnt);
  assign stab_inc = sat_inc(stab_cnt);
  assign fail_inc = sat_inc(fail_cnt);
  assign judged   = CMP_BITS'(pkt_inc) > CMP_BITS'(skip_lim);
  // Simulated samples never count toward the stable run.
  assign good     = !item.is_sim && item.condition_met;

  always_comb begin
    stab_nxt = stab_cnt;
    fail_nxt = fail_cnt;
    if (judged) begin
      if (good) begin
        stab_nxt = stab_inc;
      end else begin
        stab_nxt = '0;
        fail_nxt = fail_inc;
      end
    end
  end

  assign fire_met = judged && good && (CMP_BITS'(stab_nxt) > CMP_BITS'(stable_lim));
  assign fire_gu  = judged && !good && (give_up_lim != '0) &&
                    (CMP_BITS'(fail_nxt) > CMP_BITS'(give_up_lim));

  always_comb begin
    ctl = '0;
    ctl.event_res = mcq_pkg::EV_NONE;
    if (is_arm) begin
      nxt_word = {item.skip_limit, item.stable_limit, item.give_up_limit,
                  {(3 * COUNT_BITS){1'b0}}};
      ctl.wr_en     = in_range;
      ctl.set_armed = in_range;
    end else begin
      nxt_word  = {skip_lim, stable_lim, give_up_lim, pkt_inc, stab_nxt, fail_nxt};
      ctl.wr_en = in_range && armed;
      if (in_range && armed && fire_met) begin
        ctl.event_res = mcq_pkg::EV_MET;
        ctl.clr_armed = 1'b1;
      end else if (in_range && armed && fire_gu) begin
        ctl.event_res = mcq_pkg::EV_GAVE_UP;
        ctl.clr_armed = 1'b1;
      end
    end
  end

endmodule

// ----- rtl/monitor_condition_qualifier.sv -----
// Monitor condition qualifier: one item per clock unless stalled. An accepted
// item is held in the input stage, and the result register loads from it as
// that stage advances. The entry table is read at acceptance and written as
// the item leaves the input stage, so one read-modify-write of one table port
// pair sets throughput; a write to the entry the next item reads is forwarded.
// The input stalls only while the input stage holds an item and the result
// register holds a stalled result. Every item, including arm requests and
// out-of-range indexes, yields exactly one result item (event_res of none
// when nothing fired). No clearing pass is needed after reset.
// Depends on mcq_pkg, mcq_ram, mcq_update and the assertion macro header.
`timescale 1ns / 1ps
`include "monitor_condition_qualifier_assert.svh"

module monitor_condition_qualifier #(
  parameter int ENTRIES    = mcq_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = mcq_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mcq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mcq_pkg::out_item_t out_data
);

  localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WORD_BITS = 3 * mcq_pkg::LIMIT_BITS + 3 * COUNT_BITS;

  logic                 accept, s1_adv, s1_in_range, s1_armed, fwd_nxt;
  logic                 s1_valid_r, s1_fwd_r, out_valid_r;
  logic [IDX_BITS-1:0]  s1_addr;
  logic [ENTRIES-1:0]   armed_r;
  logic [WORD_BITS-1:0] ram_rdata, cur_word, nxt_word, fwd_data_r;
  mcq_pkg::in_item_t    s1_item_r;
  mcq_pkg::out_item_t   out_data_r;
  mcq_pkg::upd_ctl_t    upd;

  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  assign s1_addr     = IDX_BITS'(s1_item_r.entry_index);
  assign s1_in_range = 32'(s1_item_r.entry_index) < ENTRIES;
  assign s1_armed    = s1_in_range ? armed_r[s1_addr] : 1'b0;

  // The entry written at this edge is the one the newly accepted item reads.
  assign fwd_nxt  = accept && s1_valid_r && s1_adv && upd.wr_en &&
                    (s1_item_r.entry_index == in_data.entry_index);
  assign cur_word = s1_fwd_r ? fwd_data_r : ram_rdata;

  mcq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (s1_valid_r && s1_adv && upd.wr_en),
    .wr_addr (s1_addr),
    .wr_data (nxt_word),
    .rd_en   (accept),
    .rd_addr (IDX_BITS'(in_data.entry_index)),
    .rd_data (ram_rdata)
  );

  mcq_update #(
    .COUNT_BITS (COUNT_BITS)
  ) u_update (
    .item     (s1_item_r),
    .in_range (s1_in_range),
    .armed    (s1_armed),
    .cur_word (cur_word),
    .nxt_word (nxt_word),
    .ctl      (upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s1_fwd_r    <= 1'b0;
      out_valid_r <= 1'b0;
      armed_r     <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        s1_fwd_r   <= fwd_nxt;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
        s1_fwd_r   <= 1'b0;
      end
      if (s1_valid_r && s1_adv) begin
        out_valid_r <= 1'b1;
        if (upd.set_armed) begin
          armed_r[s1_addr] <= 1'b1;
        end else if (upd.clr_armed) begin
          armed_r[s1_addr] <= 1'b0;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
    end
    if (fwd_nxt) begin
      fwd_data_r <= nxt_word;
    end
    if (s1_valid_r && s1_adv) begin
      out_data_r.event_res   <= upd.event_res;
      out_data_r.event_index <= (upd.event_res == mcq_pkg::EV_NONE) ?
                                '0 : s1_item_r.entry_index;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MCQ_ASSERT_IMP(a_stall_cause, in_stall, s1_valid_r && out_valid_r && out_stall,
                  "input stalled without a full pipeline")
  `MCQ_ASSERT_IMP(a_event_source, s1_valid_r && upd.event_res != mcq_pkg::EV_NONE,
                  s1_item_r.req_type == mcq_pkg::REQ_SAMPLE && s1_armed,
                  "event raised by an arm request or a disarmed entry")
  `MCQ_ASSERT_NXT(a_fire_disarms,
                  s1_valid_r && s1_adv && upd.event_res != mcq_pkg::EV_NONE,
                  !armed_r[$past(s1_addr)], "entry still armed after firing")
  `MCQ_ASSERT_IMP(a_fwd_valid, s1_fwd_r, s1_valid_r,
                  "forwarded entry data without an item in stage one")

endmodule
